@@ design/ifa_pkg.sv @@
// Package for integer_format_to_ascii: character codes, command/status structs
// and the digit-to-ASCII helper. No dependencies.
`timescale 1ns / 1ps
package ifa_pkg;

    localparam int VALUE_W = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W = 4 * BCD_DIGITS;
    localparam int IDX_W = 4;
    localparam int BIT_CNT_W = 5;

    localparam logic [IDX_W-1:0] DEC_TOP_IDX = IDX_W'(BCD_DIGITS - 1);
    localparam logic [IDX_W-1:0] HEX_TOP_IDX = IDX_W'(VALUE_W / 4 - 1);
    localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = BIT_CNT_W'(VALUE_W - 1);

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_LOWER_D = 8'h64;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] HEX_LETTER_OFFSET = 8'd55;

    typedef struct packed {
        logic accept;
        logic start_conv;
        logic is_dec;
        logic dd_step;
        logic skip_step;
        logic emit_char;
        logic emit_minus;
        logic emit_digit;
    } ifa_cmd_t;

    typedef struct packed {
        logic neg;
        logic bit_done;
        logic idx_zero;
        logic digit_zero;
    } ifa_sts_t;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
        logic [7:0] d8;
        d8 = {4'h0, d};
        return (d > 4'd9) ? d8 + HEX_LETTER_OFFSET : d8 + CH_ZERO;
    endfunction

endpackage

@@ design/ifa_if.sv @@
// Stream interfaces for the format-character input and the ASCII output.
// Depends on nothing.
`timescale 1ns / 1ps
interface ifa_fmt_if;
    logic               valid;
    logic               ready;
    logic [7:0]         format_char;
    logic signed [31:0] number;
    logic               starts_string;

    modport source (output valid, format_char, number, starts_string, input ready);
    modport sink   (input valid, format_char, number, starts_string, output ready);
endinterface

interface ifa_txt_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, out_char, last_of_run, input ready);
    modport sink   (input valid, out_char, last_of_run, output ready);
endinterface

@@ design/ifa_dp.sv @@
// Datapath: stored value, double-dabble BCD converter, digit index and output char.
// Depends on ifa_pkg.
`timescale 1ns / 1ps
module ifa_dp
    import ifa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ifa_cmd_t             cmd,
    input  logic [7:0]           format_char,
    input  logic [VALUE_W-1:0]   number,
    input  logic                 starts_string,
    output ifa_sts_t             sts,
    output logic [7:0]           out_char
);

    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [7:0]           char_reg, char_next;

    logic [VALUE_W-1:0] v_eff;
    logic [VALUE_W-1:0] mag;
    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         digit;

    assign v_eff = starts_string ? number : value_reg;
    assign mag   = v_eff[VALUE_W-1] ? VALUE_W'(0) - v_eff : v_eff;
    assign digit = bcd_reg[{idx_reg, 2'b00} +: 4];

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        value_next   = value_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        idx_next     = idx_reg;
        char_next    = char_reg;

        if (cmd.accept)
        begin
            value_next = cmd.start_conv ? VALUE_W'(0) : v_eff;
        end
        if (cmd.start_conv)
        begin
            if (cmd.is_dec)
            begin
                bin_next     = mag;
                bcd_next     = '0;
                bit_cnt_next = '0;
            end
            else
            begin
                bcd_next = BCD_W'(v_eff);
                idx_next = HEX_TOP_IDX;
            end
        end
        if (cmd.dd_step)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next     = {bin_reg[VALUE_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
            if (bit_cnt_reg == BIT_CNT_LAST)
            begin
                idx_next = DEC_TOP_IDX;
            end
        end
        if (cmd.skip_step)
        begin
            idx_next = idx_reg - 1'b1;
        end
        if (cmd.emit_digit)
        begin
            char_next = digit_to_ascii(digit);
            idx_next  = idx_reg - 1'b1;
        end
        if (cmd.emit_char)
        begin
            char_next = format_char;
        end
        if (cmd.emit_minus)
        begin
            char_next = CH_MINUS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        idx_reg     <= idx_next;
        char_reg    <= char_next;
    end

    assign sts.neg        = v_eff[VALUE_W-1];
    assign sts.bit_done   = (bit_cnt_reg == BIT_CNT_LAST);
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.digit_zero = (digit == 4'h0);
    assign out_char       = char_reg;

endmodule

@@ design/ifa_ctrl.sv @@
// Controller: decodes format characters, sequences conversion and digit output,
// owns the pending-percent flag and the output beat valid. Depends on ifa_pkg.
`timescale 1ns / 1ps
module ifa_ctrl
    import ifa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] format_char,
    input  logic       starts_string,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       last_of_run,
    input  ifa_sts_t   sts,
    output ifa_cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DD   = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       pend_reg, pend_next;
    logic       valid_reg, valid_next;
    logic       last_reg, last_next;

    logic slot_free;
    logic pend_eff;

    assign slot_free = !valid_reg || out_ready;
    assign pend_eff  = !starts_string && pend_reg;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        valid_next = valid_reg && !out_ready;
        last_next  = last_reg;
        cmd        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.accept = 1'b1;
                    priority if (format_char == CH_NUL)
                    begin
                        pend_next = 1'b0;
                    end
                    else if (pend_eff)
                    begin
                        pend_next = 1'b0;
                        if (format_char == CH_LOWER_D)
                        begin
                            cmd.start_conv = 1'b1;
                            cmd.is_dec     = 1'b1;
                            state_next     = ST_DD;
                            if (sts.neg)
                            begin
                                cmd.emit_minus = 1'b1;
                                valid_next     = 1'b1;
                                last_next      = 1'b0;
                            end
                        end
                        else if (format_char == CH_LOWER_X)
                        begin
                            cmd.start_conv = 1'b1;
                            state_next     = ST_SKIP;
                        end
                    end
                    else if (format_char == CH_PERCENT)
                    begin
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        pend_next     = 1'b0;
                        cmd.emit_char = 1'b1;
                        valid_next    = 1'b1;
                        last_next     = 1'b1;
                    end
                end
            end
            ST_DD:
            begin
                cmd.dd_step = 1'b1;
                if (sts.bit_done)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (sts.digit_zero && !sts.idx_zero)
                begin
                    cmd.skip_step = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit_digit = 1'b1;
                    valid_next     = 1'b1;
                    last_next      = sts.idx_zero;
                    if (sts.idx_zero)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid   = valid_reg;
    assign last_of_run = last_reg;

endmodule

@@ design/integer_format_to_ascii.sv @@
// A plain character or the minus sign is registered and valid in the cycle after its beat. A %x
// item skips leading zero digits, then emits; a %d item first runs the double-dabble conversion,
// then skips leading zeros and emits. Digits follow one per cycle while the output is not stalled.
// The block is sequential: the next beat is taken with the last character of the item, so a new
// item is not taken before the current one is through, and output stalls hold it.
// Reset (rst_n, async low) clears the stored value, pending percent and output valid.
`timescale 1ns / 1ps
module integer_format_to_ascii
    import ifa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ifa_fmt_if.sink   fmt,
    ifa_txt_if.source txt
);

    ifa_cmd_t cmd;
    ifa_sts_t sts;

    ifa_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (fmt.valid),
        .in_ready      (fmt.ready),
        .format_char   (fmt.format_char),
        .starts_string (fmt.starts_string),
        .out_valid     (txt.valid),
        .out_ready     (txt.ready),
        .last_of_run   (txt.last_of_run),
        .sts           (sts),
        .cmd           (cmd)
    );

    ifa_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .format_char   (fmt.format_char),
        .number        (VALUE_W'(unsigned'(fmt.number))),
        .starts_string (fmt.starts_string),
        .sts           (sts),
        .out_char      (txt.out_char)
    );

endmodule

@@ design/ifa_checker.sv @@
// Port-level checker for integer_format_to_ascii, bound to the top level.
// Depends on ifa_pkg.
`timescale 1ns / 1ps
module ifa_checker
    import ifa_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       fmt_valid,
    input logic       fmt_ready,
    input logic [7:0] format_char,
    input logic       starts_string,
    input logic       txt_valid,
    input logic       txt_ready,
    input logic [7:0] out_char,
    input logic       last_of_run
);

    logic fmt_beat;
    assign fmt_beat = fmt_valid && fmt_ready;

    a_txt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid && !txt_ready |=> txt_valid)
        else $error("output beat dropped before ready");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        fmt_ready |-> !(txt_valid && !txt_ready))
        else $error("input taken while output stalled");

    a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid && !last_of_run |-> !fmt_ready)
        else $error("input taken during a conversion");

    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        fmt_beat && starts_string && format_char != CH_NUL && format_char != CH_PERCENT
        |=> txt_valid && last_of_run && out_char == $past(format_char))
        else $error("plain character not passed through");

    a_nul_silent: assert property (@(posedge clk) disable iff (!rst_n)
        fmt_beat && format_char == CH_NUL |=> !txt_valid)
        else $error("zero character produced output");

endmodule

bind integer_format_to_ascii ifa_checker u_ifa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .fmt_valid     (fmt.valid),
    .fmt_ready     (fmt.ready),
    .format_char   (fmt.format_char),
    .starts_string (fmt.starts_string),
    .txt_valid     (txt.valid),
    .txt_ready     (txt.ready),
    .out_char      (txt.out_char),
    .last_of_run   (txt.last_of_run)
);

@@ bench/tb_integer_format_to_ascii.sv @@
// Testbench for integer_format_to_ascii: drives format-string beats with random gaps and
// back-pressure, predicts the ASCII output stream and checks it character by character.
// Depends on design/ifa_pkg.sv, design/ifa_if.sv and design/integer_format_to_ascii.sv.
`timescale 1ns / 1ps
module tb_integer_format_to_ascii;
    import ifa_pkg::*;

    localparam int RANDOM_BEATS = 154;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PLAN_ROWS = 26;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } glyph_t;

    typedef struct {
        logic [7:0]  ch;
        logic [31:0] num;
        bit          first;
        bit          typed;
        string       want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ifa_fmt_if fmt ();
    ifa_txt_if txt ();

    integer_format_to_ascii dut (
        .clk   (clk),
        .rst_n (rst_n),
        .fmt   (fmt),
        .txt   (txt)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // formatter state mirrored on the bench side
    bit          pct_armed;
    logic [31:0] held_value;

    glyph_t expected_text[$];
    int     mismatches;
    int     beats_sent;
    int     cycle_count;
    bit     quiet;
    int     stall_left;

    // directed rows: extremes, dropped letters, trailing percent, zero character
    plan_row_t plan [PLAN_ROWS] = '{
        '{"A",         32'h0000_0000, 1'b1, 1'b1, "A"},
        '{CH_PERCENT,  32'h0000_0000, 1'b0, 1'b1, ""},
        '{CH_LOWER_D,  32'h0000_0000, 1'b0, 1'b1, "0"},
        '{CH_PERCENT,  32'h8000_0000, 1'b1, 1'b1, ""},
        '{CH_LOWER_D,  32'h0000_0000, 1'b0, 1'b1, "-2147483648"},
        '{CH_PERCENT,  32'h0000_0000, 1'b0, 1'b1, ""},
        '{CH_LOWER_X,  32'h0000_0000, 1'b0, 1'b1, "0"},
        '{CH_PERCENT,  32'hFFFF_FFFF, 1'b1, 1'b1, ""},
        '{CH_LOWER_X,  32'h0000_0000, 1'b0, 1'b1, "FFFFFFFF"},
        '{CH_PERCENT,  32'h7FFF_FFFF, 1'b1, 1'b1, ""},
        '{CH_LOWER_D,  32'h0000_0000, 1'b0, 1'b1, "2147483647"},
        '{CH_PERCENT,  32'd1000000000, 1'b1, 1'b1, ""},
        '{CH_LOWER_D,  32'h0000_0000, 1'b0, 1'b1, "1000000000"},
        '{CH_PERCENT,  32'hFFFF_CFC7, 1'b1, 1'b1, ""},
        '{"q",         32'h0000_0000, 1'b0, 1'b1, ""},
        '{CH_PERCENT,  32'h0000_0000, 1'b0, 1'b1, ""},
        '{CH_PERCENT,  32'h0000_0000, 1'b0, 1'b1, ""},
        '{CH_LOWER_D,  32'h0000_0000, 1'b0, 1'b1, "d"},
        '{CH_PERCENT,  32'h0000_0000, 1'b0, 1'b1, ""},
        '{CH_LOWER_X,  32'h1234_ABCD, 1'b1, 1'b1, "x"},
        '{CH_PERCENT,  32'h0000_0000, 1'b0, 1'b1, ""},
        '{CH_NUL,      32'h0000_0000, 1'b0, 1'b1, ""},
        '{CH_LOWER_X,  32'h0000_0000, 1'b0, 1'b1, "x"},
        '{CH_PERCENT,  32'h0000_0000, 1'b0, 1'b1, ""},
        '{CH_LOWER_X,  32'h0000_0000, 1'b0, 1'b1, "1234ABCD"},
        '{8'hFF,       32'h0000_0000, 1'b0, 1'b0, ""}
    };

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic string predict_text(logic [7:0] ch, logic [31:0] num, bit first);
        string       text;
        logic [31:0] mag;
        logic [3:0]  nib;
        bit          as_dec;
        text = "";
        if (first)
        begin
            held_value = num;
            pct_armed = 1'b0;
        end
        if (ch == CH_NUL)
            pct_armed = 1'b0;
        else if (pct_armed)
        begin
            pct_armed = 1'b0;
            if (ch == CH_LOWER_D || ch == CH_LOWER_X)
            begin
                as_dec = (ch == CH_LOWER_D);
                mag = (as_dec && held_value[31]) ? -held_value : held_value;
                do
                begin
                    if (as_dec)
                    begin
                        text = {$sformatf("%c", 8'(mag % 10) + "0"), text};
                        mag = mag / 10;
                    end
                    else
                    begin
                        nib = mag[3:0];
                        text = {$sformatf("%c", (nib < 10) ? 8'(nib) + "0" : 8'(nib - 10) + "A"),
                                text};
                        mag = mag >> 4;
                    end
                end
                while (mag != 0);
                if (as_dec && held_value[31])
                    text = {$sformatf("%c", CH_MINUS), text};
                held_value = '0;
            end
        end
        else if (ch == CH_PERCENT)
            pct_armed = 1'b1;
        else
            text = $sformatf("%c", ch);
        return text;
    endfunction

    task automatic send_beat(logic [7:0] ch, logic [31:0] num, bit first, bit typed, string want);
        string text;
        int    gap;
        fmt.format_char <= ch;
        fmt.number <= num;
        fmt.starts_string <= first;
        fmt.valid <= 1'b1;
        do
            @(posedge clk);
        while (!fmt.ready);
        text = predict_text(ch, num, first);
        if (typed)
            text = want;
        for (int i = 0; i < text.len(); i++)
            expected_text.push_back('{ch: text[i], last: (i == text.len() - 1)});
        beats_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            fmt.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // one well-formed string with random content; a few dropped letters and zero characters
    task automatic send_string();
        logic [31:0] num;
        logic [7:0]  other;
        bit          first;
        int          n_tok;
        case ($urandom_range(0, 5))
            0: num = $urandom;
            1: num = $urandom_range(0, 15);
            2: num = -$urandom_range(1, 1000);
            3:
            begin
                case ($urandom_range(0, 3))
                    0: num = 32'h8000_0000;
                    1: num = 32'h7FFF_FFFF;
                    2: num = 32'hFFFF_FFFF;
                    default: num = '0;
                endcase
            end
            4: num = $urandom_range(0, 99999);
            default: num = $urandom >> $urandom_range(0, 31);
        endcase
        first = 1'b1;
        n_tok = $urandom_range(1, 5);
        for (int t = 0; t < n_tok; t++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    send_beat(8'($urandom_range(1, 255)), first ? num : $urandom, first,
                              1'b0, "");
                3, 4, 5:
                begin
                    send_beat(CH_PERCENT, first ? num : $urandom, first, 1'b0, "");
                    send_beat(CH_LOWER_D, $urandom, 1'b0, 1'b0, "");
                end
                6, 7:
                begin
                    send_beat(CH_PERCENT, first ? num : $urandom, first, 1'b0, "");
                    send_beat(CH_LOWER_X, $urandom, 1'b0, 1'b0, "");
                end
                8:
                begin
                    other = 8'($urandom_range(0, 255));
                    send_beat(CH_PERCENT, first ? num : $urandom, first, 1'b0, "");
                    send_beat(other, $urandom, 1'b0, 1'b0, "");
                end
                default:
                    send_beat(CH_NUL, first ? num : $urandom, first, 1'b0, "");
            endcase
            first = 1'b0;
        end
        if ($urandom_range(0, 5) == 0)
            send_beat(CH_PERCENT, $urandom, 1'b0, 1'b0, "");
    endtask

    // output back-pressure
    always @(posedge clk)
    begin
        int g;
        if (stall_left > 0)
            stall_left--;
        else
        begin
            g = pick_gap();
            if (g == 0)
                txt.ready <= 1'b1;
            else
            begin
                txt.ready <= 1'b0;
                stall_left = g - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        glyph_t exp_glyph;
        if (rst_n && txt.valid && txt.ready)
        begin
            if (expected_text.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: char %h last %b", txt.out_char, txt.last_of_run);
            end
            else
            begin
                exp_glyph = expected_text.pop_front();
                if (txt.out_char !== exp_glyph.ch || txt.last_of_run !== exp_glyph.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected char %h last %b, got char %h last %b",
                                 exp_glyph.ch, exp_glyph.last, txt.out_char, txt.last_of_run);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("integer_format_to_ascii test failed");
            $finish;
        end
    end

    initial
    begin
        fmt.valid = 1'b0;
        fmt.format_char = '0;
        fmt.number = '0;
        fmt.starts_string = 1'b0;
        txt.ready = 1'b0;
        pct_armed = 1'b0;
        held_value = '0;
        mismatches = 0;
        beats_sent = 0;
        cycle_count = 0;
        quiet = 1'b0;
        stall_left = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
            send_beat(plan[i].ch, plan[i].num, plan[i].first, plan[i].typed, plan[i].want);

        while (beats_sent < PLAN_ROWS + RANDOM_BEATS)
        begin
            // a stretch with no gaps on either side
            quiet = (beats_sent > PLAN_ROWS + 60 && beats_sent < PLAN_ROWS + 100);
            send_string();
        end
        quiet = 1'b0;
        fmt.valid <= 1'b0;

        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_text.size() == 0)
            $display("integer_format_to_ascii test passed");
        else
            $display("integer_format_to_ascii test failed");
        $finish;
    end

endmodule

@@ integer_format_to_ascii.f @@
design/ifa_pkg.sv
design/ifa_if.sv
design/ifa_dp.sv
design/ifa_ctrl.sv
design/integer_format_to_ascii.sv
design/ifa_checker.sv
bench/tb_integer_format_to_ascii.sv
